### src/gumowski_mira_map_iterator_macros.svh
// Assertion macros for the Gumowski-Mira map iterator sequencer
`ifndef GUMOWSKI_MIRA_MAP_ITERATOR_MACROS_SVH
`define GUMOWSKI_MIRA_MAP_ITERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define GMM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define GMM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/gmm_pkg.sv
// Shared constants, types and microcode ROM of the Gumowski-Mira map iterator
package gmm_pkg;

    localparam int FRAC_BITS   = 24;
    localparam int COUNT_WIDTH = 16;
    localparam int DATA_W      = 32;
    localparam int NPTS_W      = 16;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int DIV_NUM_W   = DATA_W + FRAC_BITS;
    localparam int DIV_ITER    = DATA_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_ITER + 1);
    localparam int PC_W        = 5;
    localparam int CFG_ADDR_W  = 5;

    localparam longint QONE = longint'(1) << FRAC_BITS;

    localparam logic [DATA_W-1:0] Q_ONE   = DATA_W'(QONE);
    localparam logic [DATA_W-1:0] RST_U   = DATA_W'(-((QONE + 64'sd2) / 64'sd5));
    localparam logic [DATA_W-1:0] RST_A   = DATA_W'((2 * QONE + 64'sd12) / 64'sd25);
    localparam logic [DATA_W-1:0] RST_B   = DATA_W'((QONE + 64'sd10) / 64'sd20);
    localparam logic [DATA_W-1:0] RST_SX  = DATA_W'((QONE + 64'sd5) / 64'sd10);
    localparam logic [DATA_W-1:0] RST_SY  = '0;
    localparam logic [NPTS_W-1:0] RST_NPTS = NPTS_W'(1000);

    localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_U, REG_A, REG_B, REG_SX, REG_SY, REG_NPTS
    } cfg_reg_t;

    typedef struct packed {
        logic [DATA_W-1:0] u;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] sx;
        logic [DATA_W-1:0] sy;
        logic [NPTS_W-1:0] num_points;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_NOP, OP_MUL, OP_WMUL, OP_ADD, OP_SUB, OP_DIV, OP_WDIV
    } op_t;

    typedef enum logic [3:0] {
        SEL_ZERO, SEL_ONE, SEL_U, SEL_A, SEL_B, SEL_SX, SEL_SY,
        SEL_X, SEL_Y, SEL_G, SEL_W, SEL_T0, SEL_T1, SEL_T2
    } sel_t;

    typedef enum logic [2:0] {
        DST_NONE, DST_X, DST_Y, DST_G, DST_W, DST_T0, DST_T1, DST_T2
    } dst_t;

    typedef enum logic [2:0] {
        BR_NEXT, BR_GOTO, BR_WAIT_IN, BR_WAIT_DIV, BR_IF_RST, BR_EMIT
    } br_t;

    typedef struct packed {
        op_t  op;
        sel_t sa;
        sel_t sb;
        sel_t sc;
        dst_t dst;
    } dp_ctl_t;

    typedef struct packed {
        dp_ctl_t          ctl;
        br_t              br;
        logic [PC_W-1:0]  target;
    } uword_t;

    typedef struct packed {
        logic valid;
        logic last;
    } emit_t;

    localparam logic [PC_W-1:0] PC_IDLE = PC_W'(0);
    localparam logic [PC_W-1:0] PC_ADV  = PC_W'(1);
    localparam logic [PC_W-1:0] PC_GFUN = PC_W'(11);
    localparam logic [PC_W-1:0] PC_DIV  = PC_W'(20);
    localparam logic [PC_W-1:0] PC_WDIV = PC_W'(21);
    localparam logic [PC_W-1:0] PC_EMIT = PC_W'(25);
    localparam logic [PC_W-1:0] PC_RST  = PC_W'(26);

    function automatic uword_t uw(op_t op, sel_t sa, sel_t sb, sel_t sc, dst_t dst,
                                  br_t br, logic [PC_W-1:0] tgt);
        uword_t w;
        w.ctl.op  = op;
        w.ctl.sa  = sa;
        w.ctl.sb  = sb;
        w.ctl.sc  = sc;
        w.ctl.dst = dst;
        w.br      = br;
        w.target  = tgt;
        return w;
    endfunction

    // Advance: x' = y + a(1-b*y^2)*y + G(x), then G(x'), y' = G(x') - x.
    // Restart: load start point, then G(start_x).
    function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            PC_W'(0):  w = uw(OP_NOP,  SEL_ZERO, SEL_ZERO, SEL_ZERO, DST_NONE, BR_WAIT_IN,  PC_RST);
            PC_W'(1):  w = uw(OP_MUL,  SEL_Y,    SEL_Y,    SEL_ZERO, DST_NONE, BR_NEXT,     PC_IDLE);
            PC_W'(2):  w = uw(OP_WMUL, SEL_ZERO, SEL_ZERO, SEL_ZERO, DST_T0,   BR_NEXT,     PC_IDLE);
            PC_W'(3):  w = uw(OP_MUL,  SEL_B,    SEL_T0,   SEL_ZERO, DST_NONE, BR_NEXT,     PC_IDLE);
            PC_W'(4):  w = uw(OP_WMUL, SEL_ZERO, SEL_ZERO, SEL_ZERO, DST_T0,   BR_NEXT,     PC_IDLE);
            PC_W'(5):  w = uw(OP_SUB,  SEL_ONE,  SEL_T0,   SEL_ZERO, DST_T0,   BR_NEXT,     PC_IDLE);
            PC_W'(6):  w = uw(OP_MUL,  SEL_A,    SEL_T0,   SEL_ZERO, DST_NONE, BR_NEXT,     PC_IDLE);
            PC_W'(7):  w = uw(OP_WMUL, SEL_ZERO, SEL_ZERO, SEL_ZERO, DST_T0,   BR_NEXT,     PC_IDLE);
            PC_W'(8):  w = uw(OP_MUL,  SEL_T0,   SEL_Y,    SEL_ZERO, DST_NONE, BR_NEXT,     PC_IDLE);
            PC_W'(9):  w = uw(OP_WMUL, SEL_ZERO, SEL_ZERO, SEL_ZERO, DST_T0,   BR_NEXT,     PC_IDLE);
            PC_W'(10): w = uw(OP_ADD,  SEL_Y,    SEL_T0,   SEL_G,    DST_W,    BR_NEXT,     PC_IDLE);
            PC_W'(11): w = uw(OP_MUL,  SEL_W,    SEL_W,    SEL_ZERO, DST_NONE, BR_NEXT,     PC_IDLE);
            PC_W'(12): w = uw(OP_WMUL, SEL_ZERO, SEL_ZERO, SEL_ZERO, DST_T0,   BR_NEXT,     PC_IDLE);
            PC_W'(13): w = uw(OP_SUB,  SEL_ONE,  SEL_U,    SEL_ZERO, DST_T1,   BR_NEXT,     PC_IDLE);
            PC_W'(14): w = uw(OP_ADD,  SEL_T1,   SEL_T1,   SEL_ZERO, DST_T1,   BR_NEXT,     PC_IDLE);
            PC_W'(15): w = uw(OP_MUL,  SEL_T1,   SEL_T0,   SEL_ZERO, DST_NONE, BR_NEXT,     PC_IDLE);
            PC_W'(16): w = uw(OP_WMUL, SEL_ZERO, SEL_ZERO, SEL_ZERO, DST_T1,   BR_NEXT,     PC_IDLE);
            PC_W'(17): w = uw(OP_ADD,  SEL_ONE,  SEL_T0,   SEL_ZERO, DST_T0,   BR_NEXT,     PC_IDLE);
            PC_W'(18): w = uw(OP_MUL,  SEL_U,    SEL_W,    SEL_ZERO, DST_NONE, BR_NEXT,     PC_IDLE);
            PC_W'(19): w = uw(OP_WMUL, SEL_ZERO, SEL_ZERO, SEL_ZERO, DST_T2,   BR_NEXT,     PC_IDLE);
            PC_W'(20): w = uw(OP_DIV,  SEL_T1,   SEL_T0,   SEL_ZERO, DST_NONE, BR_NEXT,     PC_IDLE);
            PC_W'(21): w = uw(OP_WDIV, SEL_ZERO, SEL_ZERO, SEL_ZERO, DST_T1,   BR_WAIT_DIV, PC_IDLE);
            PC_W'(22): w = uw(OP_ADD,  SEL_T2,   SEL_T1,   SEL_ZERO, DST_G,    BR_IF_RST,   PC_EMIT);
            PC_W'(23): w = uw(OP_SUB,  SEL_G,    SEL_X,    SEL_ZERO, DST_Y,    BR_NEXT,     PC_IDLE);
            PC_W'(24): w = uw(OP_ADD,  SEL_W,    SEL_ZERO, SEL_ZERO, DST_X,    BR_NEXT,     PC_IDLE);
            PC_W'(25): w = uw(OP_NOP,  SEL_ZERO, SEL_ZERO, SEL_ZERO, DST_NONE, BR_EMIT,     PC_IDLE);
            PC_W'(26): w = uw(OP_ADD,  SEL_SX,   SEL_ZERO, SEL_ZERO, DST_X,    BR_NEXT,     PC_IDLE);
            PC_W'(27): w = uw(OP_ADD,  SEL_SY,   SEL_ZERO, SEL_ZERO, DST_Y,    BR_NEXT,     PC_IDLE);
            PC_W'(28): w = uw(OP_ADD,  SEL_SX,   SEL_ZERO, SEL_ZERO, DST_W,    BR_GOTO,     PC_GFUN);
            default:   w = uw(OP_NOP,  SEL_ZERO, SEL_ZERO, SEL_ZERO, DST_NONE, BR_GOTO,     PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

### src/gmm_regs.sv
// Configuration register bank with APB-style access
module gmm_regs
    import gmm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [DATA_W-1:0] u_reg, a_reg, b_reg, sx_reg, sy_reg;
    logic [NPTS_W-1:0] npts_reg;
    cfg_reg_t          idx;
    logic              wr;

    assign idx    = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_reg    <= RST_U;
            a_reg    <= RST_A;
            b_reg    <= RST_B;
            sx_reg   <= RST_SX;
            sy_reg   <= RST_SY;
            npts_reg <= RST_NPTS;
        end else if (wr) begin
            case (idx)
                REG_U:    u_reg    <= pwdata;
                REG_A:    a_reg    <= pwdata;
                REG_B:    b_reg    <= pwdata;
                REG_SX:   sx_reg   <= pwdata;
                REG_SY:   sy_reg   <= pwdata;
                REG_NPTS: npts_reg <= pwdata[NPTS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_U:    prdata = u_reg;
            REG_A:    prdata = a_reg;
            REG_B:    prdata = b_reg;
            REG_SX:   prdata = sx_reg;
            REG_SY:   prdata = sy_reg;
            REG_NPTS: prdata = DATA_W'(npts_reg);
            default:  prdata = '0;
        endcase
    end

    assign cfg.u          = u_reg;
    assign cfg.a          = a_reg;
    assign cfg.b          = b_reg;
    assign cfg.sx         = sx_reg;
    assign cfg.sy         = sy_reg;
    assign cfg.num_points = npts_reg;

endmodule

### src/gmm_divider.sv
// Radix-4 restoring divider for the rounded fixed-point quotient t / den
module gmm_divider
    import gmm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] num,
    input  logic [DATA_W-1:0] den,
    output logic              busy,
    output logic [DATA_W-1:0] quo,
    output logic              ovf
);

    logic [DATA_W-1:0]    rem_reg, low_reg, den_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [DATA_W-1:0]    mag;
    logic [DIV_NUM_W-1:0] nfull;
    logic [2*DATA_W-1:0]  s1, s2;

    function automatic logic [2*DATA_W-1:0] div_step(logic [DATA_W-1:0] r,
                                                     logic [DATA_W-1:0] l,
                                                     logic [DATA_W-1:0] d);
        logic [DATA_W:0] r1;
        logic            ge;
        r1 = {r, l[DATA_W-1]};
        ge = (r1 >= {1'b0, d});
        if (ge) begin
            r1 = r1 - {1'b0, d};
        end
        return {r1[DATA_W-1:0], l[DATA_W-2:0], ge};
    endfunction

    // numerator |t| * 2^F plus half the divisor, so the quotient rounds half away
    assign mag   = num[DATA_W-1] ? (~num + DATA_W'(1)) : num;
    assign nfull = {mag, {FRAC_BITS{1'b0}}} + DIV_NUM_W'(den >> 1);
    assign s1    = div_step(rem_reg, low_reg, den_reg);
    assign s2    = div_step(s1[2*DATA_W-1:DATA_W], s1[DATA_W-1:0], den_reg);
    assign busy  = (cnt_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= DIV_CNT_W'(DIV_ITER);
        end else if (busy) begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DATA_W'(nfull[DIV_NUM_W-1:DATA_W]);
            low_reg <= nfull[DATA_W-1:0];
            den_reg <= den;
            neg_reg <= num[DATA_W-1];
        end else if (busy) begin
            rem_reg <= s2[2*DATA_W-1:DATA_W];
            low_reg <= s2[DATA_W-1:0];
        end
    end

    always_comb begin
        if (neg_reg) begin
            ovf = (low_reg > S_MIN);
            quo = ovf ? S_MIN : (~low_reg + DATA_W'(1));
        end else begin
            ovf = low_reg[DATA_W-1];
            quo = ovf ? S_MAX : low_reg;
        end
    end

endmodule

### src/gmm_datapath.sv
// Register file, shared multiplier, adder and divider driven by the control word
module gmm_datapath
    import gmm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_ctl_t           ctl,
    input  logic              sat_clr,
    input  cfg_t              cfg,
    output logic              div_busy,
    output logic [DATA_W-1:0] point_x,
    output logic [DATA_W-1:0] point_y,
    output logic              saturated
);

    logic [DATA_W-1:0] x_reg, y_reg, g_reg, w_reg, t0_reg, t1_reg, t2_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              sat_reg;

    logic [DATA_W-1:0]        opa, opb, opc, wval, div_quo;
    logic signed [PROD_W-1:0] sum, rnd, shf;
    logic [DATA_W:0]          cl_mul, cl_sum;
    logic                     we, wsat, div_ovf, div_start;

    function automatic logic [DATA_W-1:0] operand(sel_t s, cfg_t c,
            logic [DATA_W-1:0] x, logic [DATA_W-1:0] y, logic [DATA_W-1:0] g,
            logic [DATA_W-1:0] w, logic [DATA_W-1:0] t0, logic [DATA_W-1:0] t1,
            logic [DATA_W-1:0] t2);
        logic [DATA_W-1:0] v;
        case (s)
            SEL_ZERO: v = '0;
            SEL_ONE:  v = Q_ONE;
            SEL_U:    v = c.u;
            SEL_A:    v = c.a;
            SEL_B:    v = c.b;
            SEL_SX:   v = c.sx;
            SEL_SY:   v = c.sy;
            SEL_X:    v = x;
            SEL_Y:    v = y;
            SEL_G:    v = g;
            SEL_W:    v = w;
            SEL_T0:   v = t0;
            SEL_T1:   v = t1;
            SEL_T2:   v = t2;
            default:  v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [DATA_W:0] clamp(logic signed [PROD_W-1:0] v);
        logic [DATA_W:0] r;
        if (v > PROD_W'(signed'(S_MAX))) begin
            r = {1'b1, S_MAX};
        end else if (v < PROD_W'(signed'(S_MIN))) begin
            r = {1'b1, S_MIN};
        end else begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction

    assign opa = operand(ctl.sa, cfg, x_reg, y_reg, g_reg, w_reg, t0_reg, t1_reg, t2_reg);
    assign opb = operand(ctl.sb, cfg, x_reg, y_reg, g_reg, w_reg, t0_reg, t1_reg, t2_reg);
    assign opc = operand(ctl.sc, cfg, x_reg, y_reg, g_reg, w_reg, t0_reg, t1_reg, t2_reg);

    always_comb begin
        if (ctl.op == OP_SUB) begin
            sum = PROD_W'(signed'(opa)) - PROD_W'(signed'(opb));
        end else begin
            sum = PROD_W'(signed'(opa)) + PROD_W'(signed'(opb)) + PROD_W'(signed'(opc));
        end
    end

    // round half up, then floor shift
    assign rnd    = signed'(prod_reg) + (PROD_W'(1) <<< (FRAC_BITS - 1));
    assign shf    = rnd >>> FRAC_BITS;
    assign cl_mul = clamp(shf);
    assign cl_sum = clamp(sum);

    assign div_start = (ctl.op == OP_DIV);

    gmm_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (opa),
        .den     (opb),
        .busy    (div_busy),
        .quo     (div_quo),
        .ovf     (div_ovf)
    );

    always_comb begin
        we   = 1'b0;
        wval = cl_sum[DATA_W-1:0];
        wsat = cl_sum[DATA_W];
        case (ctl.op)
            OP_WMUL: begin
                we   = 1'b1;
                wval = cl_mul[DATA_W-1:0];
                wsat = cl_mul[DATA_W];
            end
            OP_ADD, OP_SUB: begin
                we = 1'b1;
            end
            OP_WDIV: begin
                we   = !div_busy;
                wval = div_quo;
                wsat = div_ovf;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.op == OP_MUL) begin
            prod_reg <= PROD_W'(signed'(opa)) * PROD_W'(signed'(opb));
        end
        if (we) begin
            case (ctl.dst)
                DST_X:  x_reg  <= wval;
                DST_Y:  y_reg  <= wval;
                DST_G:  g_reg  <= wval;
                DST_W:  w_reg  <= wval;
                DST_T0: t0_reg <= wval;
                DST_T1: t1_reg <= wval;
                DST_T2: t2_reg <= wval;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg <= 1'b0;
        end else if (sat_clr) begin
            sat_reg <= 1'b0;
        end else if (we && wsat && ctl.dst != DST_NONE) begin
            sat_reg <= 1'b1;
        end
    end

    assign point_x   = x_reg;
    assign point_y   = y_reg;
    assign saturated = sat_reg;

endmodule

### src/gmm_sequencer.sv
// Microcode sequencer: step counter, branch control and iteration count
`include "gumowski_mira_map_iterator_macros.svh"

module gmm_sequencer
    import gmm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              restart,
    output logic              s_tready,
    input  logic              div_busy,
    input  logic              out_busy,
    input  logic [NPTS_W-1:0] num_points,
    output dp_ctl_t           ctl,
    output logic              sat_clr,
    output emit_t             emit
);

    logic [PC_W-1:0]        pc_reg, pc_next;
    logic                   rst_mode_reg, rst_mode_next;
    logic                   init_reg, init_next;
    logic [COUNT_WIDTH-1:0] idx_reg, idx_next;
    uword_t                 uword;
    logic                   accept;

    assign uword    = ucode_rom(pc_reg);
    assign ctl      = uword.ctl;
    assign s_tready = (uword.br == BR_WAIT_IN);
    assign accept   = s_tvalid && s_tready;
    assign sat_clr  = accept;

    always_comb begin
        pc_next       = pc_reg + PC_W'(1);
        rst_mode_next = rst_mode_reg;
        init_next     = init_reg;
        idx_next      = idx_reg;
        emit.valid    = 1'b0;
        emit.last     = (DATA_W'(idx_reg) == DATA_W'(num_points));
        case (uword.br)
            BR_NEXT: begin
            end
            BR_GOTO: begin
                pc_next = uword.target;
            end
            BR_WAIT_IN: begin
                if (!accept) begin
                    pc_next = pc_reg;
                end else if (restart) begin
                    pc_next       = uword.target;
                    rst_mode_next = 1'b1;
                    idx_next      = '0;
                end else begin
                    rst_mode_next = 1'b0;
                    idx_next      = idx_reg + COUNT_WIDTH'(1);
                end
            end
            BR_WAIT_DIV: begin
                if (div_busy) begin
                    pc_next = pc_reg;
                end
            end
            BR_IF_RST: begin
                if (rst_mode_reg) begin
                    pc_next = uword.target;
                end
            end
            BR_EMIT: begin
                if (init_reg) begin
                    init_next = 1'b0;
                    pc_next   = uword.target;
                end else if (out_busy) begin
                    pc_next = pc_reg;
                end else begin
                    emit.valid = 1'b1;
                    pc_next    = uword.target;
                end
            end
            default: begin
                pc_next = PC_IDLE;
            end
        endcase
    end

    // reset runs the restart program silently to compute G of the start point
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= PC_RST;
            rst_mode_reg <= 1'b1;
            init_reg     <= 1'b1;
            idx_reg      <= '0;
        end else begin
            pc_reg       <= pc_next;
            rst_mode_reg <= rst_mode_next;
            init_reg     <= init_next;
            idx_reg      <= idx_next;
        end
    end

    `GMM_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, !s_tready, "ready after transfer")
    `GMM_ASSERT_NOW(a_emit_free, aclk, aresetn, emit.valid, !out_busy && !init_reg, "emit blocked")
    `GMM_ASSERT_NEXT(a_div_started, aclk, aresetn, pc_reg == PC_DIV, div_busy, "divider idle")

endmodule

### src/gumowski_mira_map_iterator.sv
// Gumowski-Mira map iterator top level: stream ports, APB registers, output register
//
// Each transfer on the s_ side is one tick: restart (s_tdata[0]) = 1 reloads the start
// point and returns it, 0 advances the map one iteration and returns (x', y') in Q8.24.
// Both run as microcode programs on one shared 32x32 multiplier (issue and writeback in
// two steps) and the radix-4 divider for the x^2/(1+x^2) term; a new item is taken only
// once the previous result has been emitted. After reset the block computes G of the
// start point with s_tready low.
// A finished result waits in the m_ register while the next item is taken.
module gumowski_mira_map_iterator
    import gmm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*DATA_W-1:0]   m_tdata,   // [31:0] point_x, [63:32] point_y
    output logic                  m_tlast,
    output logic [0:0]            m_tuser,   // [0] saturated
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    cfg_t              cfg;
    dp_ctl_t           ctl;
    emit_t             emit;
    logic              sat_clr, div_busy, out_busy, saturated;
    logic [DATA_W-1:0] point_x, point_y;

    logic                m_valid_reg;
    logic [2*DATA_W-1:0] m_data_reg;
    logic                m_last_reg;
    logic                m_sat_reg;

    gmm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gmm_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sat_clr   (sat_clr),
        .cfg       (cfg),
        .div_busy  (div_busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .saturated (saturated)
    );

    gmm_sequencer u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .restart    (s_tdata[0]),
        .s_tready   (s_tready),
        .div_busy   (div_busy),
        .out_busy   (out_busy),
        .num_points (cfg.num_points),
        .ctl        (ctl),
        .sat_clr    (sat_clr),
        .emit       (emit)
    );

    assign out_busy = m_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            m_data_reg <= {point_y, point_x};
            m_last_reg <= emit.last;
            m_sat_reg  <= saturated;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_sat_reg;

endmodule

### dv/testbench.sv
// Self-checking testbench for the Gumowski-Mira map iterator: stream ticks, APB setup, Q8.24 predictor
`timescale 1ns / 1ps

module testbench;
    import gmm_pkg::*;

    localparam int ITEMS_PER_PHASE = 91;
    localparam int RANDOM_PHASES   = 8;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int END_SETTLE      = 100;
    localparam int MAX_REPORTS     = 10;
    localparam logic [2:0] UNMAPPED_SLOT = 3'd6;

    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    typedef struct {
        int x;
        int y;
        bit last;
        bit sat;
    } point_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;   // [0] restart, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [2*DATA_W-1:0]   m_tdata;         // [31:0] point_x, [63:32] point_y
    logic                  m_tlast;
    logic [0:0]            m_tuser;         // [0] saturated
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0]     pwdata   = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    gumowski_mira_map_iterator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Register mirror and map state
    int                     cfg_u, cfg_a, cfg_b, cfg_sx, cfg_sy;
    logic [NPTS_W-1:0]      cfg_npts;
    int                     map_x, map_y, map_g;
    logic [COUNT_WIDTH-1:0] map_index;
    bit                     clamp_hit;

    bit         pending_ticks[$];
    point_t     expected_points[$];
    idle_mode_t idle_mode = IDLE_NONE;
    int         error_count = 0;
    int         quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int sat32(longint v);
        if (v > longint'(signed'(S_MAX))) begin
            clamp_hit = 1'b1;
            return S_MAX;
        end
        if (v < longint'(signed'(S_MIN))) begin
            clamp_hit = 1'b1;
            return S_MIN;
        end
        return int'(v);
    endfunction

    function automatic int q_mul(int p, int q);
        longint prod;
        prod = longint'(p) * longint'(q) + (QONE >>> 1);
        return sat32(prod >>> FRAC_BITS);
    endfunction

    function automatic int q_div(int t, int den);
        longint num;
        longint d;
        longint quo;
        num = longint'(t) * QONE;
        d   = longint'(den);
        if (num >= 0)
            quo = (num + d / 2) / d;
        else
            quo = (num - d / 2) / d;
        return sat32(quo);
    endfunction

    function automatic int g_of(int x, int u);
        int x2, omu, two_omu, t, den, quo, ux;
        x2      = q_mul(x, x);
        omu     = sat32(QONE - longint'(u));
        two_omu = sat32(2 * longint'(omu));
        t       = q_mul(two_omu, x2);
        den     = sat32(QONE + longint'(x2));
        quo     = q_div(t, den);
        ux      = q_mul(u, x);
        return sat32(longint'(ux) + longint'(quo));
    endfunction

    function automatic void add_tick(bit restart_bit);
        pending_ticks.insert(pending_ticks.size(), restart_bit);
    endfunction

    function automatic void predict_tick(bit restart);
        int y2, by2, f, af, afy, xn, gn, yn;
        point_t pt;
        clamp_hit = 1'b0;
        if (restart) begin
            map_x     = cfg_sx;
            map_y     = cfg_sy;
            map_g     = g_of(map_x, cfg_u);
            map_index = '0;
        end else begin
            y2  = q_mul(map_y, map_y);
            by2 = q_mul(cfg_b, y2);
            f   = sat32(QONE - longint'(by2));
            af  = q_mul(cfg_a, f);
            afy = q_mul(af, map_y);
            xn  = sat32(longint'(map_y) + longint'(afy) + longint'(map_g));
            gn  = g_of(xn, cfg_u);
            yn  = sat32(longint'(gn) - longint'(map_x));
            map_x     = xn;
            map_y     = yn;
            map_g     = gn;
            map_index = map_index + 1'b1;
        end
        pt.x    = map_x;
        pt.y    = map_y;
        pt.last = (map_index == cfg_npts);
        pt.sat  = clamp_hit;
        expected_points.insert(expected_points.size(), pt);
    endfunction

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function automatic bit idle_roll(bit sender_side);
        int pct;
        pct = 0;
        case (idle_mode)
            IDLE_SENDER:   pct = sender_side ? 50 : 0;
            IDLE_RECEIVER: pct = sender_side ? 0 : 50;
            IDLE_BOTH:     pct = 9;
            default:       pct = 0;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    // Driver: hold each transfer until accepted, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_tick(s_tdata[0]);
            if (!s_tvalid || s_tready) begin
                if (pending_ticks.size() > 0 && !idle_roll(1'b1)) begin
                    s_tdata  <= {7'b0, pending_ticks.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        point_t pt;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    flag_error($sformatf("unexpected result x=%h y=%h", m_tdata[31:0],
                                         m_tdata[63:32]));
                end else begin
                    pt = expected_points.pop_front();
                    if (m_tdata[31:0] !== pt.x[31:0] || m_tdata[63:32] !== pt.y[31:0]
                        || m_tlast !== pt.last || m_tuser[0] !== pt.sat)
                        flag_error($sformatf(
                            "exp x=%h y=%h last=%b sat=%b, got x=%h y=%h last=%b sat=%b",
                            pt.x, pt.y, pt.last, pt.sat, m_tdata[31:0], m_tdata[63:32],
                            m_tlast, m_tuser[0]));
                end
            end
            m_tready <= !idle_roll(1'b0);
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] slot, logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({slot, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (slot)
            REG_U:    cfg_u    = value;
            REG_A:    cfg_a    = value;
            REG_B:    cfg_b    = value;
            REG_SX:   cfg_sx   = value;
            REG_SY:   cfg_sy   = value;
            REG_NPTS: cfg_npts = value[NPTS_W-1:0];
            default:  ;
        endcase
    endtask

    task automatic load_config(int u, int a, int b, int sx, int sy, logic [DATA_W-1:0] npts);
        write_reg(REG_U, u);
        write_reg(REG_A, a);
        write_reg(REG_B, b);
        write_reg(REG_SX, sx);
        write_reg(REG_SY, sy);
        write_reg(REG_NPTS, npts);
    endtask

    task automatic drain();
        while (pending_ticks.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(negedge aclk);
    endtask

    function automatic int pick_signed(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int pick_corner();
        case ($urandom_range(0, 3))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return 0;
            default: return Q_ONE;
        endcase
    endfunction

    initial begin
        int qone;
        qone      = int'(QONE);
        cfg_u     = RST_U;
        cfg_a     = RST_A;
        cfg_b     = RST_B;
        cfg_sx    = RST_SX;
        cfg_sy    = RST_SY;
        cfg_npts  = RST_NPTS;
        map_x     = RST_SX;
        map_y     = 0;
        map_g     = g_of(map_x, cfg_u);
        map_index = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // advance from the reset state before any restart
        idle_mode = IDLE_NONE;
        repeat (3) add_tick(1'b0);
        add_tick(1'b1);
        repeat (3) add_tick(1'b0);
        drain();

        // last flag on restart with a zero count, then on a reached count
        idle_mode = IDLE_BOTH;
        write_reg(REG_NPTS, 32'd0);
        add_tick(1'b1);
        add_tick(1'b0);
        drain();
        write_reg(REG_NPTS, 32'hFFFF_0002);
        add_tick(1'b1);
        repeat (3) add_tick(1'b0);
        drain();

        // saturation corners and an unmapped register write
        idle_mode = IDLE_NONE;
        load_config(S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, 32'd1);
        write_reg(UNMAPPED_SLOT, $urandom);
        add_tick(1'b1);
        repeat (2) add_tick(1'b0);
        drain();
        load_config(S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, 32'hFFFF);
        add_tick(1'b1);
        repeat (2) add_tick(1'b0);
        drain();
        load_config(0, 0, 0, 0, 0, 32'd1);
        add_tick(1'b1);
        add_tick(1'b0);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            idle_mode = idle_mode_t'(ph % 4);
            case ($urandom_range(0, 3))
                0, 1: load_config(pick_signed(qone), pick_signed(qone / 4),
                                  pick_signed(qone / 4), pick_signed(4 * qone),
                                  pick_signed(4 * qone), $urandom_range(0, 60));
                2:    load_config($urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom);
                default: load_config(pick_corner(), pick_corner(), pick_corner(),
                                     pick_corner(), pick_corner(),
                                     ($urandom_range(0, 1) != 0) ? 32'hFFFF
                                                                 : $urandom_range(0, 30));
            endcase
            if ($urandom_range(0, 7) != 0)
                add_tick(1'b1);
            repeat (ITEMS_PER_PHASE) add_tick($urandom_range(0, 29) == 0);
            drain();
        end

        repeat (END_SETTLE) @(posedge aclk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
